[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the ordered list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hdl/oldk_pkg.sv]
// Package with the codes and result type of the ordered list block.
`timescale 1ns / 1ps

package oldk_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  localparam logic [2:0] ST_APPENDED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_DUMP     = 3'd4;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] entry;
    logic               empty_res;
    logic               last;
  } res_t;

endpackage

[hdl/oldk_mem.sv]
// Entry memory: one write port and one synchronous read port with registered data.
`timescale 1ns / 1ps

module oldk_mem #(
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [31:0]              wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [31:0]              rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/oldk_outq.sv]
// Output register that holds one result until the receiver takes it.
`timescale 1ns / 1ps

module oldk_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  oldk_pkg::res_t push_res_i,
  output logic          slot_free_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output oldk_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  oldk_pkg::res_t res_q;

  assign slot_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= push_res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[hdl/ordered_list_delete_by_key.sv]
// Ordered list of identifiers with append, remove by value and dump.
//
// Input channel: in_valid_i, in_stall_o, operation_i, value_i. A transfer
// happens when valid is high and stall is low. Output channel: out_valid_o,
// out_stall_i, status_o, entry_o, empty_res_o, last_o.
// Every item runs alone through a sequencer around one entry memory with a
// registered read; the next transfer is taken once the sequencer is idle
// again, even while the last result still waits in the output register.
// Remove, found or not: the search and the shift together visit every entry
// once. Dump: one result per entry, head first, last flagged; an empty list
// answers with a single result that has empty_res set. Operation code 3
// gives no result. Reset empties the list at once; no clearing pass is needed
// since only entries below the occupancy are ever read. While the receiver
// stalls, the result stays in the output register and the sequencer waits on
// it before it pushes another result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ordered_list_delete_by_key #(
  parameter int DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] entry_o,
  output logic               empty_res_o,
  output logic               last_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_RM_RD  = 4'd2;
  localparam logic [3:0] S_RM_CMP = 4'd3;
  localparam logic [3:0] S_SH_RD  = 4'd4;
  localparam logic [3:0] S_SH_WR  = 4'd5;
  localparam logic [3:0] S_DP_RD  = 4'd6;
  localparam logic [3:0] S_DP_EM  = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] idx_inc;
  logic [1:0]    op_q, op_d;
  logic [31:0]   val_q, val_d;
  logic [2:0]    resp_status_q, resp_status_d;
  logic          resp_empty_q, resp_empty_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;

  logic           push, slot_free;
  oldk_pkg::res_t push_res, out_res;

  oldk_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  oldk_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_res_i (push_res),
    .slot_free_o(slot_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (out_res)
  );

  assign status_o    = out_res.status;
  assign entry_o     = out_res.entry;
  assign empty_res_o = out_res.empty_res;
  assign last_o      = out_res.last;

  assign in_stall_o = (state_q != S_IDLE);
  assign idx_inc    = idx_q + CW'(1);

  always_comb begin
    state_d       = state_q;
    occ_d         = occ_q;
    idx_d         = idx_q;
    op_d          = op_q;
    val_d         = val_q;
    resp_status_d = resp_status_q;
    resp_empty_d  = resp_empty_q;
    mem_we        = 1'b0;
    mem_waddr     = idx_q[AW-1:0];
    mem_wdata     = val_q;
    mem_re        = 1'b0;
    mem_raddr     = idx_q[AW-1:0];
    push          = 1'b0;
    push_res      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          val_d   = value_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        resp_empty_d = 1'b0;
        idx_d        = '0;
        unique case (op_q)
          oldk_pkg::OP_APPEND: begin
            if (occ_q == FULL_CNT) begin
              resp_status_d = oldk_pkg::ST_FULL;
            end else begin
              mem_we        = 1'b1;
              mem_waddr     = occ_q[AW-1:0];
              occ_d         = occ_q + CW'(1);
              resp_status_d = oldk_pkg::ST_APPENDED;
            end
            state_d = S_RESP;
          end
          oldk_pkg::OP_REMOVE: begin
            state_d = S_RM_RD;
          end
          oldk_pkg::OP_DUMP: begin
            if (occ_q == '0) begin
              resp_status_d = oldk_pkg::ST_DUMP;
              resp_empty_d  = 1'b1;
              state_d       = S_RESP;
            end else begin
              state_d = S_DP_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_RM_RD: begin
        if (idx_q == occ_q) begin
          resp_status_d = oldk_pkg::ST_NOTFOUND;
          state_d       = S_RESP;
        end else begin
          mem_re  = 1'b1;
          state_d = S_RM_CMP;
        end
      end
      S_RM_CMP: begin
        if (mem_rdata == val_q) begin
          state_d = S_SH_RD;
        end else begin
          idx_d   = idx_inc;
          state_d = S_RM_RD;
        end
      end
      S_SH_RD: begin
        // Reaching the tail ends the shift; the predecessor becomes the tail.
        if (idx_inc == occ_q) begin
          occ_d         = occ_q - CW'(1);
          resp_status_d = oldk_pkg::ST_REMOVED;
          state_d       = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[AW-1:0];
          state_d   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_d     = idx_inc;
        state_d   = S_SH_RD;
      end
      S_DP_RD: begin
        mem_re  = 1'b1;
        state_d = S_DP_EM;
      end
      S_DP_EM: begin
        if (slot_free) begin
          push               = 1'b1;
          push_res.status    = oldk_pkg::ST_DUMP;
          push_res.entry     = mem_rdata;
          push_res.empty_res = 1'b0;
          push_res.last      = (idx_inc == occ_q);
          idx_d              = idx_inc;
          state_d            = (idx_inc == occ_q) ? S_IDLE : S_DP_RD;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          push               = 1'b1;
          push_res.status    = resp_status_q;
          push_res.entry     = '0;
          push_res.empty_res = resp_empty_q;
          push_res.last      = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    op_q          <= op_d;
    val_q         <= val_d;
    resp_status_q <= resp_status_d;
    resp_empty_q  <= resp_empty_d;
  end

  `ASSERT_ALWAYS(a_occ_bound, !rst_ni || (occ_q <= FULL_CNT), "occupancy exceeds depth")
  `ASSERT_CLK(a_accept_exec, (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC),
              "accepted transfer did not start execution")
  `ASSERT_CLK(a_write_states, mem_we |-> ((state_q == S_EXEC) || (state_q == S_SH_WR)),
              "memory written outside append or shift")
  `ASSERT_CLK(a_shift_nonempty, (state_q == S_SH_RD) |-> (idx_q < occ_q),
              "shift position beyond the list")

endmodule

[tb/ordered_list_delete_by_key_tb.sv]
// Self-checking testbench for the ordered list block with append, remove by value and dump.
`timescale 1ns / 1ps

module ordered_list_delete_by_key_tb;

  localparam int LIST_DEPTH = 32;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         operation_i;
  logic signed [31:0] value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [2:0]         status_o;
  logic signed [31:0] entry_o;
  logic               empty_res_o;
  logic               last_o;

  // Mirror of the list contents, head at index 0.
  logic [31:0]    list_model[$];
  oldk_pkg::res_t expected_results[$];
  logic [31:0]    key_pool[8];
  bit             idle_en;
  int             fail_count;
  int             quiet_cycles;
  int             stall_left;
  oldk_pkg::res_t got_res;
  oldk_pkg::res_t want_res;

  ordered_list_delete_by_key #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .entry_o    (entry_o),
    .empty_res_o(empty_res_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one operation to the list mirror and queues the results it causes.
  task automatic predict_list_op(input logic [1:0] op, input logic [31:0] val);
    oldk_pkg::res_t r;
    int   hit;
    int   n;
    r.status    = oldk_pkg::ST_APPENDED;
    r.entry     = '0;
    r.empty_res = 1'b0;
    r.last      = 1'b1;
    hit         = -1;
    case (op)
      oldk_pkg::OP_APPEND: begin
        if (list_model.size() >= LIST_DEPTH) begin
          r.status = oldk_pkg::ST_FULL;
        end else begin
          list_model.push_back(val);
          r.status = oldk_pkg::ST_APPENDED;
        end
        expected_results.push_back(r);
      end
      oldk_pkg::OP_REMOVE: begin
        for (int i = 0; i < list_model.size(); i++) begin
          if (hit < 0 && list_model[i] == val) hit = i;
        end
        if (hit < 0) begin
          r.status = oldk_pkg::ST_NOTFOUND;
        end else begin
          list_model.delete(hit);
          r.status = oldk_pkg::ST_REMOVED;
        end
        expected_results.push_back(r);
      end
      oldk_pkg::OP_DUMP: begin
        r.status = oldk_pkg::ST_DUMP;
        n = list_model.size();
        if (n == 0) begin
          r.empty_res = 1'b1;
          expected_results.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.entry = list_model[i];
            r.last  = (i == n - 1);
            expected_results.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [1:0] op, input logic [31:0] val);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    do @(posedge clk_i); while (in_stall_o);
    predict_list_op(op, val);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return key_pool[$urandom_range(0, 7)];
  endfunction

  // Mostly removes keys that are present so that the shift path gets exercised.
  function automatic logic [31:0] pick_remove_key();
    if (list_model.size() != 0 && $urandom_range(0, 9) < 7)
      return list_model[$urandom_range(0, list_model.size() - 1)];
    return pick_key();
  endfunction

  // Receiver stall bursts of random length, started only while idle_en is set.
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(0, 16);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checker and watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (in_valid_i && !in_stall_o) quiet_cycles = 0;
      if (out_valid_o && !out_stall_i) begin
        quiet_cycles      = 0;
        got_res.status    = status_o;
        got_res.entry     = entry_o;
        got_res.empty_res = empty_res_o;
        got_res.last      = last_o;
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d entry %0d", status_o, entry_o);
          fail_count++;
        end else begin
          want_res = expected_results.pop_front();
          if (got_res.status !== want_res.status) begin
            $error("status: expected %0d, actual %0d", want_res.status, got_res.status);
            fail_count++;
          end
          if (got_res.entry !== want_res.entry) begin
            $error("entry: expected %0d, actual %0d", want_res.entry, got_res.entry);
            fail_count++;
          end
          if (got_res.empty_res !== want_res.empty_res) begin
            $error("empty_res: expected %0d, actual %0d", want_res.empty_res,
                   got_res.empty_res);
            fail_count++;
          end
          if (got_res.last !== want_res.last) begin
            $error("last: expected %0d, actual %0d", want_res.last, got_res.last);
            fail_count++;
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic test_empty_list();
    send_item(oldk_pkg::OP_DUMP, 32'h0);
    send_item(oldk_pkg::OP_REMOVE, 32'h0);
    send_item(oldk_pkg::OP_REMOVE, 32'h8000_0000);
  endtask

  task automatic test_unused_operation();
    send_item(OP_UNUSED, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 32'h0);
  endtask

  task automatic test_append_extremes();
    send_item(oldk_pkg::OP_APPEND, 32'h8000_0000);
    send_item(oldk_pkg::OP_APPEND, 32'h7FFF_FFFF);
    send_item(oldk_pkg::OP_APPEND, 32'h0);
    send_item(oldk_pkg::OP_APPEND, 32'hFFFF_FFFF);
    send_item(oldk_pkg::OP_DUMP, 32'hFFFF_FFFF);
  endtask

  task automatic test_remove_positions();
    send_item(oldk_pkg::OP_REMOVE, 32'hFFFF_FFFF);
    send_item(oldk_pkg::OP_APPEND, 32'd5);
    send_item(oldk_pkg::OP_REMOVE, 32'h8000_0000);
    send_item(oldk_pkg::OP_REMOVE, 32'd1234);
    send_item(oldk_pkg::OP_DUMP, 32'h0);
    send_item(oldk_pkg::OP_REMOVE, 32'h0);
    send_item(oldk_pkg::OP_DUMP, 32'h0);
  endtask

  // Only the copy nearest the head goes away.
  task automatic test_duplicate_keys();
    send_item(oldk_pkg::OP_APPEND, 32'd9);
    send_item(oldk_pkg::OP_APPEND, 32'd5);
    send_item(oldk_pkg::OP_REMOVE, 32'd5);
    send_item(oldk_pkg::OP_DUMP, 32'h0);
  endtask

  task automatic test_full_list();
    while (list_model.size() < LIST_DEPTH) send_item(oldk_pkg::OP_APPEND, pick_key());
    send_item(oldk_pkg::OP_APPEND, 32'd1);
    send_item(oldk_pkg::OP_APPEND, $urandom);
    send_item(oldk_pkg::OP_DUMP, 32'h0);
    send_item(oldk_pkg::OP_REMOVE, list_model[LIST_DEPTH-1]);
    send_item(oldk_pkg::OP_APPEND, 32'h8000_0000);
    send_item(oldk_pkg::OP_DUMP, 32'h0);
  endtask

  task automatic test_drain_to_empty();
    while (list_model.size() != 0)
      send_item(oldk_pkg::OP_REMOVE, list_model[$urandom_range(0, list_model.size() - 1)]);
    send_item(oldk_pkg::OP_DUMP, $urandom);
    send_item(oldk_pkg::OP_REMOVE, $urandom);
  endtask

  // Alternates between growing and shrinking so the occupancy sweeps its range.
  task automatic test_random_traffic(input int n_items);
    int  sent;
    int  roll;
    int  mode_left;
    bit  growing;
    sent      = 0;
    mode_left = 0;
    growing   = 1'b1;
    while (sent < n_items) begin
      if (mode_left == 0) begin
        growing   = ~growing;
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_item(OP_UNUSED, $urandom);
      end else begin
        sent++;
        if (roll < 15) send_item(oldk_pkg::OP_DUMP, $urandom);
        else if ((growing && roll < 75) || (!growing && roll < 40))
          send_item(oldk_pkg::OP_APPEND, pick_key());
        else
          send_item(oldk_pkg::OP_REMOVE, pick_remove_key());
      end
    end
  endtask

  task automatic test_pause_until_drained();
    send_item(oldk_pkg::OP_APPEND, pick_key());
    send_item(oldk_pkg::OP_DUMP, 32'h0);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    send_item(oldk_pkg::OP_REMOVE, pick_remove_key());
    send_item(oldk_pkg::OP_DUMP, 32'h0);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = oldk_pkg::OP_APPEND;
    value_i      = '0;
    idle_en      = 1'b1;
    fail_count   = 0;
    quiet_cycles = 0;
    key_pool[0]  = 32'h8000_0000;
    key_pool[1]  = 32'h7FFF_FFFF;
    key_pool[2]  = 32'h0;
    key_pool[3]  = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_unused_operation();
    test_append_extremes();
    test_remove_positions();
    test_duplicate_keys();
    test_full_list();
    test_drain_to_empty();
    test_random_traffic(270);
    test_pause_until_drained();
    idle_en = 1'b0;
    test_random_traffic(50);

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2 * LIST_DEPTH + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
